// File: design/tcq_pkg.sv
package tcq_pkg;

  localparam int NUM_BASIC = 16;
  localparam int NUM_CAND  = 4;

  // palette_mode codes; bit 1 set means passthrough
  localparam logic [1:0] MODE_BASIC = 2'd0;
  localparam logic [1:0] MODE_CUBE  = 2'd1;
  localparam int         PASS_BIT   = 1;

  localparam logic [7:0] CUBE_BASE   = 8'd16;
  localparam logic [7:0] GREY_BASE   = 8'd232;
  localparam logic [7:0] HIGH_OFFSET = 8'd52;
  localparam logic [12:0] SCALE_RND  = 13'd12;

  // fixed 16-entry xterm palette, 0xRRGGBB
  localparam logic [NUM_BASIC-1:0][23:0] BASIC_PALETTE = {
    24'hffffff, 24'h00ffff, 24'hff00ff, 24'h5c5cff,
    24'hffff00, 24'h00ff00, 24'hff0000, 24'h7f7f7f,
    24'he5e5e5, 24'h00cdcd, 24'hcd00cd, 24'h0000ee,
    24'hcdcd00, 24'h00cd00, 24'hcd0000, 24'h000000
  };

  typedef logic [17:0] dist_t;

  typedef struct packed {
    dist_t      sqd;
    logic [3:0] idx;
  } cand_t;

  // stage 1: all 16 distances plus scaled channels
  typedef struct packed {
    logic [1:0]                 mode;
    logic [23:0]                pix;
    dist_t [NUM_BASIC-1:0]      sqd;
    logic [4:0]                 rs;
    logic [4:0]                 gs;
    logic [4:0]                 bs;
  } s1_t;

  // stage 2: four surviving candidates plus 256-color code
  typedef struct packed {
    logic [1:0]                 mode;
    logic [23:0]                pix;
    cand_t [NUM_CAND-1:0]       cand;
    logic [7:0]                 cube;
  } s2_t;

  function automatic logic [15:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
    logic [7:0]  d;
    logic [15:0] p;
    d = (a > b) ? (a - b) : (b - a);
    p = d * d;
    return p;
  endfunction

  // (v*24 + 12) >> 8, result 0..23
  function automatic logic [4:0] scale24(input logic [7:0] v);
    logic [12:0] t;
    t = {1'b0, v, 4'b0} + {2'b0, v, 3'b0} + SCALE_RND;
    return t[12:8];
  endfunction

  // keep the left (lower index) entry unless the right one is strictly closer
  function automatic cand_t pick(input cand_t a, input cand_t b);
    return (b.sqd < a.sqd) ? b : a;
  endfunction

endpackage

// File: design/tcq_dist.sv
module tcq_dist (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [23:0]   in_data,
  input  logic [1:0]    mode,
  output logic          s1_valid,
  output tcq_pkg::s1_t  s1
);
  import tcq_pkg::*;

  logic       valid_r;
  s1_t        s1_r;
  s1_t        s1_nxt;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  assign red   = in_data[7:0];
  assign green = in_data[15:8];
  assign blue  = in_data[23:16];

  // squared distance to every palette entry, in parallel
  always_comb begin
    s1_nxt.mode = mode;
    s1_nxt.pix  = {red, green, blue};
    for (int k = 0; k < NUM_BASIC; k++) begin
      s1_nxt.sqd[k] = {2'b0, sq_diff(BASIC_PALETTE[k][23:16], red)}
                    + {2'b0, sq_diff(BASIC_PALETTE[k][15:8], green)}
                    + {2'b0, sq_diff(BASIC_PALETTE[k][7:0], blue)};
    end
    s1_nxt.rs = scale24(red);
    s1_nxt.gs = scale24(green);
    s1_nxt.bs = scale24(blue);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = valid_r;
  assign s1       = s1_r;

endmodule

// File: design/tcq_reduce.sv
module tcq_reduce (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          s1_valid,
  input  tcq_pkg::s1_t  s1,
  output logic          s2_valid,
  output tcq_pkg::s2_t  s2
);
  import tcq_pkg::*;

  logic       valid_r;
  s2_t        s2_r;
  s2_t        s2_nxt;
  cand_t      c0;
  cand_t      c1;
  cand_t      c2;
  cand_t      c3;
  logic [2:0] r4;
  logic [2:0] g4;
  logic [2:0] b4;
  logic       grey;

  always_comb begin
    c0 = '0;
    c1 = '0;
    c2 = '0;
    c3 = '0;
    s2_nxt.mode = s1.mode;
    s2_nxt.pix  = s1.pix;

    // first two levels of the min tree: 16 -> 4
    for (int g = 0; g < NUM_CAND; g++) begin
      c0.sqd = s1.sqd[4*g];
      c0.idx = 4'(4*g);
      c1.sqd = s1.sqd[4*g+1];
      c1.idx = 4'(4*g+1);
      c2.sqd = s1.sqd[4*g+2];
      c2.idx = 4'(4*g+2);
      c3.sqd = s1.sqd[4*g+3];
      c3.idx = 4'(4*g+3);
      s2_nxt.cand[g] = pick(pick(c0, c1), pick(c2, c3));
    end

    // grey when scaled channels agree above the low two bits
    r4   = s1.rs[4:2];
    g4   = s1.gs[4:2];
    b4   = s1.bs[4:2];
    grey = (r4 == g4) && (g4 == b4);
    if (grey) begin
      s2_nxt.cube = GREY_BASE + {3'b0, s1.rs};
    end else begin
      s2_nxt.cube = CUBE_BASE + 8'(r4) * 8'd36 + 8'(g4) * 8'd6 + 8'(b4);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2_valid = valid_r;
  assign s2       = s2_r;

endmodule

// File: design/tcq_final.sv
module tcq_final (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          s2_valid,
  input  tcq_pkg::s2_t  s2,
  output logic          out_valid,
  output logic [23:0]   out_code
);
  import tcq_pkg::*;

  logic        valid_r;
  logic [23:0] code_r;
  logic [23:0] code_nxt;
  cand_t       best;
  logic [7:0]  basic;

  always_comb begin
    // last two levels of the min tree: 4 -> 1
    best = pick(pick(s2.cand[0], s2.cand[1]), pick(s2.cand[2], s2.cand[3]));
    // bright half of the palette maps to codes 60..67
    basic = best.idx[3] ? ({4'b0, best.idx} + HIGH_OFFSET) : {4'b0, best.idx};

    priority if (s2.mode[PASS_BIT]) begin
      code_nxt = s2.pix;
    end else if (s2.mode == MODE_CUBE) begin
      code_nxt = {16'b0, s2.cube};
    end else begin
      code_nxt = {16'b0, basic};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= code_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_code  = code_r;

endmodule

// File: design/terminal_color_quantizer_top.sv
// RGB pixel to terminal color code converter.
// in_*  : pixel requests, in_tdata = {blue, green, red} (red in bits 7:0).
// out_* : one color code per pixel, in the same order, in out_tdata[23:0].
// cfg_* : palette_mode write (0 nearest of 16 colors, 1 cube and grey,
//         2 or 3 passthrough); cfg_ready is always high. Write it only
//         while no pixel is in flight.
// An accepted request reaches out_tvalid through the three-stage pipeline
// (distances, 16->4 min tree, 4->1 min tree with output register), which
// takes one pixel per cycle when the output is not stalled.
// Reset (rst_n low, synchronous) empties the pipeline and sets palette_mode
// to 0. When the receiver holds out_tready low with a result waiting, all
// stages freeze and in_tready drops; bubbles in the pipe still let a request
// in as long as the output register is empty or being taken.
module terminal_color_quantizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] color_code
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data    // [1:0] palette_mode
);
  import tcq_pkg::*;

  logic [1:0] mode_r;
  logic       en;
  logic       s1_valid;
  s1_t        s1;
  logic       s2_valid;
  s2_t        s2;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BASIC;
    end else if (cfg_valid) begin
      mode_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  // global advance: output register empty or being taken
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  tcq_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_tvalid),
    .in_data  (in_tdata),
    .mode     (mode_r),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  tcq_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  tcq_final u_final (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .out_valid (out_tvalid),
    .out_code  (out_tdata)
  );

endmodule

// File: design/tcq_checker.sv
module tcq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed or dropped");

  // empty output register never blocks requests
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // an accepted request shows up at the output when neither reset nor stall intervenes
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $past(in_tvalid && in_tready, 3) && $past(rst_n, 3) && $past(rst_n, 2) &&
    $past(rst_n, 1) && $past(out_tready, 2) && $past(out_tready, 1)
    |-> out_tvalid)
    else $error("result missing after pipeline latency");

  // reset empties the output
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present after reset");

endmodule

bind terminal_color_quantizer_top tcq_checker u_tcq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
